// ===== src/sng_pkg.sv =====
// ---------------------------------------------------------------------------
// sng_pkg: shared types and constants of the sine oscillator with glide
// Holds the controller states, the command and status bundles between the
// controller and the datapath, fixed field widths and the sine table builder.
// ---------------------------------------------------------------------------
package sng_pkg;

    // Fixed field widths
    localparam int TARGET_BITS  = 24;
    localparam int AMP_BITS     = 16;
    localparam int COUNT_BITS   = 7;
    localparam int CFG_BITS     = 32;
    localparam int HELD_BITS    = 48;
    localparam int FREQ_FRAC    = 16;
    localparam int FQ8_BITS     = HELD_BITS - FREQ_FRAC;
    localparam int INC_SHIFT    = 24;
    localparam int DIFF_BITS    = HELD_BITS + 1;
    localparam int ITER_BITS    = $clog2(DIFF_BITS);
    localparam int ROM_MAG_BITS = 15;
    localparam int PROD_BITS    = AMP_BITS + ROM_MAG_BITS;

    localparam logic [CFG_BITS-1:0] PPH_RESET = 32'd22906492;
    localparam logic [63:0]         PI_Q30    = 64'd3373259426;
    localparam logic [63:0]         ROM_PEAK  = 64'd32767;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_PREP,
        ST_MUL,
        ST_EMIT
    } sng_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture request, form target minus held frequency
        logic start_div;  // launch the step division
        logic prep;       // apply the step for the first frame
        logic mul;        // register the increment and gain products
        logic emit;       // write the output register, advance the phase
        logic adv_held;   // apply the step for the following frame
    } sng_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
        logic count_zero;
        logic last_frame;
    } sng_sts_t;

    // sin(pi/2 * r / q) * 32767 rounded, q = 2^(addr_bits-2); Q30 Taylor series
    function automatic logic [ROM_MAG_BITS-1:0] quarter_sine(input int unsigned r,
                                                             input int addr_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] v;
        longint      sum;
        if (r == 0) begin
            return '0;
        end
        x   = (PI_Q30 * 64'(r)) >> (addr_bits - 1);
        x2  = (x * x) >> 30;
        t   = x;
        sum = longint'(x);
        t   = ((t * x2) >> 30) / 6;
        sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 20;
        sum = sum + longint'(t);
        t   = ((t * x2) >> 30) / 42;
        sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 72;
        sum = sum + longint'(t);
        t   = ((t * x2) >> 30) / 110;
        sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 156;
        sum = sum + longint'(t);
        t   = ((t * x2) >> 30) / 210;
        sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 272;
        sum = sum + longint'(t);
        t   = ((t * x2) >> 30) / 342;
        sum = sum - longint'(t);
        if (sum <= 0) begin
            return '0;
        end
        v = (64'(sum) * ROM_PEAK + 64'd536870912) >> 30;
        if (v > ROM_PEAK) begin
            v = ROM_PEAK;
        end
        return v[ROM_MAG_BITS-1:0];
    endfunction

endpackage

// ===== src/sng_div.sv =====
// ---------------------------------------------------------------------------
// sng_div: serial signed divider for the per-frame frequency step
// Restoring division, one quotient bit per cycle, quotient truncated toward
// zero and wrapped to the held frequency width.
// ---------------------------------------------------------------------------
module sng_div #(
    parameter int DIVISOR_BITS = 7
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [sng_pkg::DIFF_BITS-1:0] dividend,
    input  logic        [DIVISOR_BITS-1:0]       divisor,
    output logic signed [sng_pkg::HELD_BITS-1:0] quotient,
    output logic                                 done
);

    localparam int DW = sng_pkg::DIFF_BITS;
    localparam int IW = sng_pkg::ITER_BITS;

    logic                    busy_reg, busy_next;
    logic                    fin_reg, fin_next;
    logic [IW-1:0]           iter_reg;
    logic [DW-1:0]           acc_reg;
    logic [DIVISOR_BITS-1:0] rem_reg;
    logic                    neg_reg;
    logic signed [sng_pkg::HELD_BITS-1:0] quot_reg;

    logic [DIVISOR_BITS:0]   trial;
    logic                    fits;
    logic [DIVISOR_BITS:0]   trial_sub;
    logic [DW-1:0]           signed_q;

    // One restoring step
    assign trial     = {rem_reg, acc_reg[DW-1]};
    assign fits      = trial >= {1'b0, divisor};
    assign trial_sub = trial - {1'b0, divisor};
    assign signed_q  = neg_reg ? (~acc_reg + DW'(1)) : acc_reg;

    // Sequence the iterations
    always_comb begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        if (start) begin
            busy_next = 1'b1;
        end else if (busy_reg && iter_reg == IW'(DW - 1)) begin
            busy_next = 1'b0;
            fin_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
        end
    end

    // Shift dividend out, quotient in; apply the sign at the end
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg  <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
            neg_reg  <= dividend[DW-1];
            rem_reg  <= '0;
            iter_reg <= '0;
        end else if (busy_reg) begin
            acc_reg  <= {acc_reg[DW-2:0], fits};
            rem_reg  <= fits ? trial_sub[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
            iter_reg <= iter_reg + IW'(1);
        end
        if (fin_reg) begin
            quot_reg <= signed_q[sng_pkg::HELD_BITS-1:0];
        end
    end

    assign quotient = quot_reg;
    assign done     = fin_reg;

endmodule

// ===== src/sng_dp.sv =====
// ---------------------------------------------------------------------------
// sng_dp: datapath of the sine oscillator with glide
// Held frequency and phase state, step division, sine quarter table, the
// increment and gain multipliers, saturation and the output register.
// ---------------------------------------------------------------------------
module sng_dp #(
    parameter int MAX_FRAMES     = 64,
    parameter int PHASE_BITS     = 24,
    parameter int SINE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  sng_pkg::sng_cmd_t                      cmd,
    output sng_pkg::sng_sts_t                      sts,
    input  logic signed [sng_pkg::TARGET_BITS-1:0] target_freq,
    input  logic        [sng_pkg::AMP_BITS-1:0]    amplitude,
    input  logic        [sng_pkg::COUNT_BITS-1:0]  frame_count,
    input  logic                                   cfg_we,
    input  logic        [sng_pkg::CFG_BITS-1:0]    cfg_data,
    output logic signed [SAMPLE_BITS-1:0]          sample,
    output logic                                   last
);

    localparam int CW   = $clog2(MAX_FRAMES + 1);
    localparam int HW   = sng_pkg::HELD_BITS;
    localparam int DW   = sng_pkg::DIFF_BITS;
    localparam int QTR  = 1 << (SINE_ADDR_BITS - 2);
    localparam int QAW  = SINE_ADDR_BITS - 1;
    localparam int MW   = sng_pkg::ROM_MAG_BITS;
    localparam int PW   = sng_pkg::PROD_BITS;
    localparam int IPW  = sng_pkg::FQ8_BITS + sng_pkg::CFG_BITS + 1;

    // State and configuration
    logic [sng_pkg::CFG_BITS-1:0] pph_reg;
    logic signed [HW-1:0]         held_reg;
    logic [PHASE_BITS-1:0]        phase_reg, phase_next;

    // Per-request registers
    logic [sng_pkg::AMP_BITS-1:0] amp_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                left_reg;
    logic signed [DW-1:0]         diff_reg;
    logic [CW-1:0]                count_sat;
    logic signed [DW-1:0]         diff_next;
    logic signed [HW-1:0]         step;

    // Frame registers
    logic [MW-1:0]                rom_mag_reg;
    logic                         rom_neg_reg;
    logic [PHASE_BITS-1:0]        inc_reg;
    logic [PW-1:0]                mag_reg;
    logic                         neg_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                         last_reg;

    logic [MW-1:0]                qtab [0:QTR];
    logic [SINE_ADDR_BITS-1:0]    idx;
    logic [QAW-1:0]               qaddr;
    logic signed [sng_pkg::FQ8_BITS-1:0] fq8;
    logic signed [IPW-1:0]        inc_prod;
    logic [SAMPLE_BITS-1:0]       mag_sh;
    logic signed [SAMPLE_BITS-1:0] sample_next;

    sng_div #(
        .DIVISOR_BITS(CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start_div),
        .dividend (diff_reg),
        .divisor  (count_reg),
        .quotient (step),
        .done     (sts.div_done)
    );

    // Saturate the requested frame count
    always_comb begin
        if (32'(frame_count) > 32'(MAX_FRAMES)) begin
            count_sat = CW'(MAX_FRAMES);
        end else begin
            count_sat = CW'(frame_count);
        end
    end

    assign diff_next = {{(DW - sng_pkg::TARGET_BITS - sng_pkg::FREQ_FRAC){target_freq[23]}},
                        target_freq, {sng_pkg::FREQ_FRAC{1'b0}}}
                       - {held_reg[HW-1], held_reg};

    assign sts.count_zero = frame_count == '0;
    assign sts.last_frame = left_reg == CW'(1);

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pph_reg <= sng_pkg::PPH_RESET;
        end else if (cfg_we) begin
            pph_reg <= cfg_data;
        end
    end

    // Held frequency and phase accumulator
    assign phase_next = cmd.emit ? phase_reg + inc_reg : phase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= '0;
            phase_reg <= '0;
        end else begin
            if (cmd.prep || cmd.adv_held) begin
                held_reg <= held_reg + step;
            end
            phase_reg <= phase_next;
        end
    end

    // Capture the request and count frames
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            amp_reg   <= amplitude;
            count_reg <= count_sat;
            diff_reg  <= diff_next;
        end
        if (cmd.load) begin
            left_reg <= count_sat;
        end else if (cmd.emit) begin
            left_reg <= left_reg - CW'(1);
        end
    end

    // Quarter-wave sine table, built at elaboration
    for (genvar gi = 0; gi <= QTR; gi++) begin : g_qtab
        localparam logic [MW-1:0] ENTRY = sng_pkg::quarter_sine(gi, SINE_ADDR_BITS);
        assign qtab[gi] = ENTRY;
    end

    // Fold the phase into the first quadrant and read the table
    assign idx   = phase_next[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign qaddr = idx[SINE_ADDR_BITS-2] ? (QAW'(QTR) - {1'b0, idx[SINE_ADDR_BITS-3:0]})
                                         : {1'b0, idx[SINE_ADDR_BITS-3:0]};

    always_ff @(posedge aclk) begin
        rom_mag_reg <= qtab[qaddr];
        rom_neg_reg <= idx[SINE_ADDR_BITS-1];
    end

    // Phase increment and gain products
    assign fq8      = held_reg[HW-1:sng_pkg::FREQ_FRAC];
    assign inc_prod = IPW'(fq8) * $signed({1'b0, pph_reg});

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            inc_reg <= inc_prod[PHASE_BITS + sng_pkg::INC_SHIFT - 1:sng_pkg::INC_SHIFT];
            mag_reg <= PW'(amp_reg) * PW'(rom_mag_reg);
            neg_reg <= rom_neg_reg;
        end
    end

    // Scale down, apply the sign and saturate
    assign mag_sh = mag_reg[PW-1:PW-SAMPLE_BITS];

    always_comb begin
        if (!neg_reg) begin
            if (mag_sh > {1'b0, {(SAMPLE_BITS-1){1'b1}}}) begin
                sample_next = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            end else begin
                sample_next = mag_sh;
            end
        end else begin
            if (mag_sh > {1'b1, {(SAMPLE_BITS-1){1'b0}}}) begin
                sample_next = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            end else begin
                sample_next = -mag_sh;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            sample_reg <= sample_next;
            last_reg   <= sts.last_frame;
        end
    end

    assign sample = sample_reg;
    assign last   = last_reg;

endmodule

// ===== src/sng_ctrl.sv =====
// ---------------------------------------------------------------------------
// sng_ctrl: controller of the sine oscillator with glide
// Steps each request through capture, step division and the frame loop, and
// owns the input ready and the output valid.
// ---------------------------------------------------------------------------
module sng_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  sng_pkg::sng_sts_t sts,
    output sng_pkg::sng_cmd_t cmd
);

    sng_pkg::sng_state_t state_reg, state_next;
    logic                m_valid_reg, m_valid_next;
    logic                slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            sng_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid && !sts.count_zero) begin
                    state_next = sng_pkg::ST_SETUP;
                end
            end
            sng_pkg::ST_SETUP: begin
                cmd.start_div = 1'b1;
                state_next    = sng_pkg::ST_DIV;
            end
            sng_pkg::ST_DIV: begin
                if (sts.div_done) begin
                    state_next = sng_pkg::ST_PREP;
                end
            end
            sng_pkg::ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = sng_pkg::ST_MUL;
            end
            sng_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = sng_pkg::ST_EMIT;
            end
            sng_pkg::ST_EMIT: begin
                if (slot_free) begin
                    cmd.emit = 1'b1;
                    if (sts.last_frame) begin
                        state_next = sng_pkg::ST_IDLE;
                    end else begin
                        cmd.adv_held = 1'b1;
                        state_next   = sng_pkg::ST_MUL;
                    end
                end
            end
            default: begin
                state_next = sng_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold a beat until taken
    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sng_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== src/sine_nco_with_frequency_glide_unit.sv =====
// ---------------------------------------------------------------------------
// sine_nco_with_frequency_glide_unit: sine oscillator with frequency glide
// Each request beat (target frequency, amplitude, frame count) produces one
// sample beat per frame while the frequency ramps toward the target.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel takes one request beat; frame counts above MAX_FRAMES are
//   clipped, a zero count is taken and produces nothing.
//   m_* channel gives one sample beat per frame, m_last on the final one.
//   cfg_* channel writes phase_per_hz; write it only while the block is idle.
// Sequence:
//   A request passes through a setup step, the serial step divider, a
//   register that signs the quotient, a state that applies the first
//   frequency step, then for each frame a multiply and an emit; the emit
//   waits while the output register holds a beat that is not yet taken.
//   s_ready is high only between requests.
// Reset: phase and held frequency clear, phase_per_hz returns to 22906492.
// Stall: when m_ready stays low the frame loop waits with the sample in the
//   output register; the next request is taken while the final sample waits.
// ---------------------------------------------------------------------------
module sine_nco_with_frequency_glide_unit #(
    parameter int MAX_FRAMES     = 64,
    parameter int PHASE_BITS     = 24,
    parameter int SINE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [sng_pkg::TARGET_BITS-1:0] s_target_freq,
    input  logic        [sng_pkg::AMP_BITS-1:0]    s_amplitude,
    input  logic        [sng_pkg::COUNT_BITS-1:0]  s_frame_count,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [SAMPLE_BITS-1:0]          m_sample,
    output logic                                   m_last,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [sng_pkg::CFG_BITS-1:0]    cfg_data
);

    sng_pkg::sng_cmd_t cmd;
    sng_pkg::sng_sts_t sts;

    assign cfg_ready = 1'b1;

    sng_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sng_dp #(
        .MAX_FRAMES     (MAX_FRAMES),
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .target_freq (s_target_freq),
        .amplitude   (s_amplitude),
        .frame_count (s_frame_count),
        .cfg_we      (cfg_valid),
        .cfg_data    (cfg_data),
        .sample      (m_sample),
        .last        (m_last)
    );

    // Never overwrite a beat that has not been taken
    a_emit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid || m_ready))
        else $error("sample emitted over a waiting beat");

    // Divider finishes only while a request is in progress
    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> !s_ready)
        else $error("divider done while idle");

    // A zero-frame request leaves the block ready
    a_zero_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_frame_count == '0) |=> s_ready)
        else $error("zero-frame request started a block");

    // The final frame returns to idle and marks the beat as last
    a_last_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && sts.last_frame) |=> (s_ready && m_valid && m_last))
        else $error("final frame not flagged or block not idle");

endmodule
